@@ design/cmse_pkg.sv @@
package cmse_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_PUSH = 4'b1000
  } seq_state_t;

  // Serial EEPROM protocol phases, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_CMD   = 5'b00010,
    PH_READ  = 5'b00100,
    PH_WRITE = 5'b01000,
    PH_WRAL  = 5'b10000
  } phase_t;

  // Bus access kinds.
  localparam logic FUNC_WRITE = 1'b1;

  // Register window select (address bits 7:4).
  localparam logic [3:0] REG_ARM    = 4'h0;
  localparam logic [3:0] REG_LATCH  = 4'h1;
  localparam logic [3:0] REG_X_LO   = 4'h2;
  localparam logic [3:0] REG_X_HI   = 4'h3;
  localparam logic [3:0] REG_Y_LO   = 4'h4;
  localparam logic [3:0] REG_Y_HI   = 4'h5;
  localparam logic [3:0] REG_ZERO   = 4'h6;
  localparam logic [3:0] REG_EEPROM = 4'h8;

  // Primary opcode (command bits 9:8) and extended opcode (bits 7:6).
  localparam logic [1:0] OP_EXT   = 2'b00;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_ERASE = 2'b11;
  localparam logic [1:0] XOP_EWDS = 2'b00;
  localparam logic [1:0] XOP_WRAL = 2'b01;
  localparam logic [1:0] XOP_ERAL = 2'b10;
  localparam logic [1:0] XOP_EWEN = 2'b11;

  // Fixed values.
  localparam logic [3:0]  ENABLE_ONE_NIBBLE = 4'hA;
  localparam logic [7:0]  ENABLE_TWO_BYTE   = 8'h40;
  localparam logic [7:0]  ARM_BYTE          = 8'h55;
  localparam logic [7:0]  LATCH_BYTE        = 8'hAA;
  localparam logic [15:0] ACCEL_CENTER      = 16'h8000;
  localparam logic [15:0] ACCEL_LATCHED     = 16'h81D0;
  localparam logic [15:0] ERASED_WORD       = 16'hFFFF;
  localparam logic [3:0]  WINDOW_PAGE       = 4'hA;
  localparam logic [3:0]  CMD_BITS          = 4'd10;
  localparam logic [4:0]  DATA_BITS         = 5'd16;
  localparam logic [4:0]  READ_BITS         = 5'd17;

endpackage

@@ design/cartridge_mapper_serial_eeprom_core.sv @@
// Cartridge bank controller with a fixed tilt latch and a three-wire serial
// EEPROM of 16-bit words.
//
// Input channel (in_*): one beat per bus access. in_tuser is the access kind
// (1 write, 0 read); in_tdata carries the address and the written byte.
// Result channel (out_*): exactly one beat per access, carrying the byte read
// (0x00 for writes), the ROM bank and the register window enable after the
// access.
//
// Timing: an accepted beat is decoded in the cycle after it is taken; a READ command
// that completes adds a fetch step that reads its word from the EEPROM memory
// (synchronous, registered read port). The result is then pushed into the output
// register from the push step. The next beat is taken as soon as the sequencer is
// idle again, even while the previous result waits in the output register; if the
// receiver stalls, the sequencer holds in its push step.
// ERAL and WRAL do not write the words one by one: they clear the per-word valid bits
// and set the fill word that unwritten words read back as.
// Reset: all control and bank state clears, the tilt words go to 0x8000 and
// every EEPROM word reads as zero; no clearing pass is needed.
module cartridge_mapper_serial_eeprom_core #(
  parameter int EEPROM_WORDS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] address, [23:16] data byte
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] byte read, [14:8] ROM bank, [15] window enable
);

  localparam int AW = $clog2(EEPROM_WORDS);

  // Sequencer and item registers
  cmse_pkg::seq_state_t state_r, state_nxt;
  logic        item_func_r;
  logic [15:0] item_addr_r;
  logic [7:0]  item_wdata_r;

  // Mapper state
  logic        en1_r, en1_nxt;
  logic        en2_r, en2_nxt;
  logic [6:0]  bank_r, bank_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] accel_r, accel_nxt;   // both axes always hold the same word

  // EEPROM pins and protocol
  logic        di_r, di_nxt;
  logic        sclk_r, sclk_nxt;
  logic        cs_r, cs_nxt;
  logic        pe_r, pe_nxt;
  cmse_pkg::phase_t phase_r, phase_nxt;
  logic [9:0]  cmd_r, cmd_nxt;
  logic [3:0]  cmd_cnt_r, cmd_cnt_nxt;
  logic [15:0] rsh_r, rsh_nxt;
  logic [4:0]  rcnt_r, rcnt_nxt;
  logic [15:0] wsh_r, wsh_nxt;
  logic [4:0]  wcnt_r, wcnt_nxt;

  // Word store: memory plus per-word valid bits and a fill word
  logic [15:0] mem [EEPROM_WORDS];
  logic [15:0] mem_q_r;
  logic [EEPROM_WORDS-1:0] valid_r;
  logic [15:0] fill_r, fill_nxt;
  logic        mem_we, mem_re, valid_clr;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;

  // Result
  logic [7:0]  rd_r, rd_nxt;
  logic        out_valid_r;
  logic [15:0] out_data_r;

  // Decode helpers
  logic        in_win;
  logic [3:0]  reg_sel;
  logic        rise;
  logic [7:0]  pin_byte;
  logic        status_bit;

  assign in_tready  = (state_r == cmse_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_win  = en1_r && en2_r && (item_addr_r[15:12] == cmse_pkg::WINDOW_PAGE);
  assign reg_sel = item_addr_r[7:4];

  always_comb begin
    case (phase_r)
      cmse_pkg::PH_READ: status_bit = (rcnt_r != 5'd0) ? rsh_r[15] : 1'b0;
      cmse_pkg::PH_CMD, cmse_pkg::PH_WRITE, cmse_pkg::PH_WRAL: status_bit = 1'b0;
      default: status_bit = 1'b1;
    endcase
  end

  assign pin_byte = {cs_r, sclk_r, 4'b0000, di_r, status_bit};

  always_comb begin
    state_nxt   = state_r;
    en1_nxt     = en1_r;
    en2_nxt     = en2_r;
    bank_nxt    = bank_r;
    armed_nxt   = armed_r;
    accel_nxt   = accel_r;
    di_nxt      = di_r;
    sclk_nxt    = sclk_r;
    cs_nxt      = cs_r;
    pe_nxt      = pe_r;
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    cmd_cnt_nxt = cmd_cnt_r;
    rsh_nxt     = rsh_r;
    rcnt_nxt    = rcnt_r;
    wsh_nxt     = wsh_r;
    wcnt_nxt    = wcnt_r;
    fill_nxt    = fill_r;
    rd_nxt      = rd_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    valid_clr   = 1'b0;
    mem_waddr   = cmd_r[AW-1:0];
    mem_raddr   = cmd_r[AW-1:0];
    mem_wdata   = cmse_pkg::ERASED_WORD;
    rise        = 1'b0;

    case (state_r)
      cmse_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = cmse_pkg::ST_EXEC;
        end
      end

      cmse_pkg::ST_EXEC: begin
        state_nxt = cmse_pkg::ST_PUSH;
        if (item_func_r == cmse_pkg::FUNC_WRITE) begin
          rd_nxt = 8'h00;
          case (item_addr_r[15:13])
            3'b000: en1_nxt = (item_wdata_r[3:0] == cmse_pkg::ENABLE_ONE_NIBBLE);
            3'b001: bank_nxt = item_wdata_r[6:0];
            3'b010: en2_nxt = (item_wdata_r == cmse_pkg::ENABLE_TWO_BYTE);
            default: begin
              if (in_win) begin
                case (reg_sel)
                  cmse_pkg::REG_ARM: begin
                    if (item_wdata_r == cmse_pkg::ARM_BYTE) begin
                      armed_nxt = 1'b1;
                      accel_nxt = cmse_pkg::ACCEL_CENTER;
                    end
                  end
                  cmse_pkg::REG_LATCH: begin
                    if (item_wdata_r == cmse_pkg::LATCH_BYTE && armed_r) begin
                      armed_nxt = 1'b0;
                      accel_nxt = cmse_pkg::ACCEL_LATCHED;
                    end
                  end
                  cmse_pkg::REG_EEPROM: begin
                    di_nxt   = item_wdata_r[1];
                    sclk_nxt = item_wdata_r[6];
                    cs_nxt   = item_wdata_r[7];
                    rise     = !sclk_r && item_wdata_r[6];
                    if (!item_wdata_r[7]) begin
                      phase_nxt = cmse_pkg::PH_IDLE;
                    end else if (rise) begin
                      case (phase_r)
                        cmse_pkg::PH_CMD: begin
                          cmd_nxt     = {cmd_r[8:0], item_wdata_r[1]};
                          cmd_cnt_nxt = cmd_cnt_r + 4'd1;
                          mem_waddr   = cmd_nxt[AW-1:0];
                          mem_raddr   = cmd_nxt[AW-1:0];
                          if (cmd_cnt_nxt >= cmse_pkg::CMD_BITS) begin
                            case (cmd_nxt[9:8])
                              cmse_pkg::OP_WRITE: begin
                                wsh_nxt   = 16'h0000;
                                wcnt_nxt  = 5'd0;
                                phase_nxt = cmse_pkg::PH_WRITE;
                              end
                              cmse_pkg::OP_READ: begin
                                mem_re    = 1'b1;
                                rcnt_nxt  = 5'd0;
                                phase_nxt = cmse_pkg::PH_READ;
                                state_nxt = cmse_pkg::ST_LOAD;
                              end
                              cmse_pkg::OP_ERASE: begin
                                mem_we    = pe_r;
                                phase_nxt = cmse_pkg::PH_IDLE;
                              end
                              default: begin
                                phase_nxt = cmse_pkg::PH_IDLE;
                                case (cmd_nxt[7:6])
                                  cmse_pkg::XOP_EWDS: pe_nxt = 1'b0;
                                  cmse_pkg::XOP_WRAL: begin
                                    wsh_nxt   = 16'h0000;
                                    wcnt_nxt  = 5'd0;
                                    phase_nxt = cmse_pkg::PH_WRAL;
                                  end
                                  cmse_pkg::XOP_ERAL: begin
                                    if (pe_r) begin
                                      valid_clr = 1'b1;
                                      fill_nxt  = cmse_pkg::ERASED_WORD;
                                    end
                                  end
                                  default: pe_nxt = 1'b1;
                                endcase
                              end
                            endcase
                          end
                        end
                        cmse_pkg::PH_WRITE, cmse_pkg::PH_WRAL: begin
                          wsh_nxt  = {wsh_r[14:0], item_wdata_r[1]};
                          wcnt_nxt = wcnt_r + 5'd1;
                          if (wcnt_nxt >= cmse_pkg::DATA_BITS) begin
                            if (pe_r) begin
                              if (phase_r == cmse_pkg::PH_WRITE) begin
                                mem_we    = 1'b1;
                                mem_wdata = wsh_nxt;
                              end else begin
                                valid_clr = 1'b1;
                                fill_nxt  = wsh_nxt;
                              end
                            end
                            phase_nxt = cmse_pkg::PH_IDLE;
                          end
                        end
                        cmse_pkg::PH_READ: begin
                          if (rcnt_r != 5'd0) begin
                            rsh_nxt = {rsh_r[14:0], 1'b0};
                          end
                          rcnt_nxt = rcnt_r + 5'd1;
                          if (rcnt_nxt >= cmse_pkg::READ_BITS) begin
                            phase_nxt = cmse_pkg::PH_IDLE;
                          end
                        end
                        default: begin
                          // start bit
                          if (item_wdata_r[1]) begin
                            phase_nxt   = cmse_pkg::PH_CMD;
                            cmd_nxt     = 10'd0;
                            cmd_cnt_nxt = 4'd0;
                          end else begin
                            phase_nxt = cmse_pkg::PH_IDLE;
                          end
                        end
                      endcase
                    end
                  end
                  default: ;
                endcase
              end
            end
          endcase
        end else begin
          rd_nxt = 8'hFF;
          if (in_win) begin
            case (reg_sel)
              cmse_pkg::REG_X_LO, cmse_pkg::REG_Y_LO: rd_nxt = accel_r[7:0];
              cmse_pkg::REG_X_HI, cmse_pkg::REG_Y_HI: rd_nxt = accel_r[15:8];
              cmse_pkg::REG_ZERO:   rd_nxt = 8'h00;
              cmse_pkg::REG_EEPROM: rd_nxt = pin_byte;
              default:              rd_nxt = 8'hFF;
            endcase
          end
        end
      end

      cmse_pkg::ST_LOAD: begin
        // word never written since reset or the last fill reads as the fill word
        rsh_nxt   = valid_r[cmd_r[AW-1:0]] ? mem_q_r : fill_r;
        state_nxt = cmse_pkg::ST_PUSH;
      end

      cmse_pkg::ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = cmse_pkg::ST_IDLE;
        end
      end

      default: state_nxt = cmse_pkg::ST_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmse_pkg::ST_IDLE;
      en1_r       <= 1'b0;
      en2_r       <= 1'b0;
      bank_r      <= 7'd0;
      armed_r     <= 1'b0;
      accel_r     <= cmse_pkg::ACCEL_CENTER;
      di_r        <= 1'b0;
      sclk_r      <= 1'b0;
      cs_r        <= 1'b0;
      pe_r        <= 1'b0;
      phase_r     <= cmse_pkg::PH_IDLE;
      cmd_r       <= 10'd0;
      cmd_cnt_r   <= 4'd0;
      rsh_r       <= 16'd0;
      rcnt_r      <= 5'd0;
      wsh_r       <= 16'd0;
      wcnt_r      <= 5'd0;
      fill_r      <= 16'd0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      en1_r     <= en1_nxt;
      en2_r     <= en2_nxt;
      bank_r    <= bank_nxt;
      armed_r   <= armed_nxt;
      accel_r   <= accel_nxt;
      di_r      <= di_nxt;
      sclk_r    <= sclk_nxt;
      cs_r      <= cs_nxt;
      pe_r      <= pe_nxt;
      phase_r   <= phase_nxt;
      cmd_r     <= cmd_nxt;
      cmd_cnt_r <= cmd_cnt_nxt;
      rsh_r     <= rsh_nxt;
      rcnt_r    <= rcnt_nxt;
      wsh_r     <= wsh_nxt;
      wcnt_r    <= wcnt_nxt;
      fill_r    <= fill_nxt;
      if (valid_clr) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      if (state_r == cmse_pkg::ST_PUSH && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: item capture, result byte, output beat
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_func_r  <= in_tuser;
      item_addr_r  <= in_tdata[15:0];
      item_wdata_r <= in_tdata[23:16];
    end
    rd_r <= rd_nxt;
    if (state_r == cmse_pkg::ST_PUSH && (!out_valid_r || out_tready)) begin
      out_data_r <= {en1_r && en2_r, bank_r, rd_r};
    end
  end

  // EEPROM word memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // The fetch step only ever follows a decode step.
  a_load_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cmse_pkg::ST_LOAD) |-> $past(state_r == cmse_pkg::ST_EXEC))
    else $error("fetch step entered without a decode step");

  // Entering the read phase always goes with a memory fetch.
  a_read_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == cmse_pkg::PH_READ && $past(phase_r != cmse_pkg::PH_READ))
      |-> (state_r == cmse_pkg::ST_LOAD))
    else $error("read phase entered without fetching the word");

  // A new result appears only out of the push step.
  a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == cmse_pkg::ST_PUSH))
    else $error("result beat raised outside the push step");

  // The command counter never runs past a full command.
  a_cmd_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_cnt_r <= cmse_pkg::CMD_BITS)
    else $error("command bit count overran");

  // No memory write and fill in the same cycle.
  a_we_vs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && valid_clr))
    else $error("word write collides with a fill");

endmodule
